// ===== sv/kdef_pkg.sv =====
// Package for the key debounce event FIFO: commands, register indexes, lane types.
// No dependencies.
package kdef_pkg;
	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_READ   = 2'd1,
		CMD_INJECT = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	localparam logic [2:0] REG_FILTER  = 3'd0;
	localparam logic [2:0] REG_THRESH  = 3'd1;
	localparam logic [2:0] REG_LONG0   = 3'd2;
	localparam logic [2:0] REG_LONG2   = 3'd4;
	localparam logic [2:0] REG_REPEAT0 = 3'd5;
	localparam logic [2:0] REG_REPEAT2 = 3'd7;

	// Events found by one key lane on a tick.
	typedef struct packed {
		logic press;
		logic release_ev;
		logic long_ev;
	} lane_ev_t;
endpackage

// ===== sv/kdef_lane.sv =====
// One key lane: hysteresis debounce, long press and auto repeat counters.
// Depends on kdef_pkg.
module kdef_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick,
	input  logic                down,
	input  logic [7:0]          filter_ticks,
	input  logic [15:0]         long_time,
	input  logic [7:0]          repeat_cycle,
	input  logic                cfg_touch,
	output logic                pressed,
	output kdef_pkg::lane_ev_t  ev
);
	import kdef_pkg::*;

	logic [8:0]  cnt_q;
	logic        pressed_q;
	logic [15:0] long_q;
	logic [7:0]  rep_q;
	logic [8:0]  f9;
	logic [8:0]  f2;
	logic [7:0]  rep_nx;
	logic        at_top;

	assign f9     = {1'b0, filter_ticks};
	assign f2     = {filter_ticks, 1'b0};
	assign rep_nx = rep_q + 8'd1;
	assign at_top = !(cnt_q < f9) && !(cnt_q < f2);
	assign pressed = pressed_q;

	always_comb begin
		ev = '0;
		if (tick && down && at_top) begin
			ev.press = !pressed_q;
			if (long_time != 16'd0) begin
				if (long_q < long_time)
					ev.long_ev = (long_q + 16'd1) == long_time;
				else if (repeat_cycle != 8'd0 && !(rep_nx < repeat_cycle))
					ev.press = 1'b1;
			end
		end
		if (tick && !down && !(cnt_q > f9) && cnt_q == 9'd0 && pressed_q)
			ev.release_ev = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= 9'd2;
			pressed_q <= 1'b0;
			long_q    <= '0;
			rep_q     <= '0;
		end else if (tick) begin
			if (down) begin
				if (cnt_q < f9)
					cnt_q <= f9;
				else if (cnt_q < f2)
					cnt_q <= cnt_q + 9'd1;
				else begin
					pressed_q <= 1'b1;
					if (long_time != 16'd0) begin
						if (long_q < long_time)
							long_q <= long_q + 16'd1;
						else if (repeat_cycle != 8'd0)
							rep_q <= (rep_nx < repeat_cycle) ? rep_nx : 8'd0;
					end
				end
			end else begin
				if (cnt_q > f9)
					cnt_q <= f9;
				else if (cnt_q != 9'd0)
					cnt_q <= cnt_q - 9'd1;
				else
					pressed_q <= 1'b0;
				long_q <= '0;
				rep_q  <= '0;
			end
		end else if (cfg_touch) begin
			rep_q <= '0;
		end
	end
endmodule

// ===== sv/kdef_fifo.sv =====
// Ring event FIFO with fill count and sticky overflow flag.
// Depends on kdef_pkg.
module kdef_fifo #(
	parameter int DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       put,
	input  logic [7:0] put_code,
	input  logic       get,
	input  logic       clear,
	output logic [7:0] get_code,
	output logic       empty,
	output logic       overflow
);
	import kdef_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [7:0]    mem [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] fill_q;
	logic          ovf_q;
	logic          full;

	assign full     = fill_q == CW'(DEPTH);
	assign empty    = fill_q == '0;
	assign overflow = ovf_q;
	assign get_code = mem[rd_q];

	always_ff @(posedge clk) begin
		if (put && !full)
			mem[wr_q] <= put_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
			ovf_q  <= 1'b0;
		end else begin
			if (clear) begin
				rd_q   <= wr_q;
				fill_q <= '0;
			end else if (put) begin
				if (full)
					ovf_q <= 1'b1;
				else begin
					wr_q   <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
					fill_q <= fill_q + CW'(1);
				end
			end else if (get && !empty) begin
				rd_q   <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
				fill_q <= fill_q - CW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH)) else $error("fill count beyond depth");
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |=> ovf_q) else $error("overflow flag dropped");
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(put && full && !clear) |=> ovf_q && $stable(wr_q)) else $error("put into full fifo");
`endif
endmodule

// ===== sv/key_debounce_event_fifo_unit.sv =====
// Top level of the key debounce event FIFO: lanes, event merge sequencer, FIFO.
// Depends on kdef_pkg, kdef_lane and kdef_fifo.
//
// Each transaction carries one command. A tick updates all key lanes at once. The
// merge sequencer then walks the lanes in key order. For each lane it takes the
// three event kinds (press, release, long press) one per cycle. Each event that
// was found goes into the FIFO, or sets the overflow flag if the FIFO is full.
// The walk always covers every lane and kind, limited by the single FIFO write
// port. The sequencer then passes through ST_DONE to ST_OUT, where the result is
// offered. From input transaction to result valid, a tick passes through ST_MERGE
// and ST_DONE, and read, inject and clear through ST_DONE alone. The result is
// held in an output register. The next command is taken in the cycle after the
// result transaction has left. Keys beyond the third never press.
module key_debounce_event_fifo_unit #(
	parameter int FIFO_DEPTH = 16,
	parameter int NUM_KEYS   = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // command[1:0], button_main, button_enable,
	                               // gyro_roll[19:4], inject_code[27:20], zeros
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // event_code[7:0], key_pressed[10:8],
	                               // fifo_overflow[11], zeros
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import kdef_pkg::*;

	localparam int LW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	typedef enum logic [1:0] {ST_IDLE, ST_MERGE, ST_DONE, ST_OUT} state_t;

	state_t       state_q;
	logic [LW-1:0] lane_q;
	logic [1:0]   kind_q;
	lane_ev_t     ev_s1 [NUM_KEYS];
	logic [7:0]   filter_q;
	logic [14:0]  thresh_q;
	logic [15:0]  long_q [NUM_KEYS];
	logic [7:0]   rep_q [NUM_KEYS];
	logic [7:0]   code_q;
	logic         read_q;

	cmd_t         cmd;
	logic         accept;
	logic         tick;
	logic signed [16:0] roll;
	logic signed [16:0] th;
	logic [NUM_KEYS-1:0] down;
	logic [NUM_KEYS-1:0] pressed;
	lane_ev_t     ev [NUM_KEYS];
	logic         put;
	logic [7:0]   put_code;
	logic [7:0]   get_code;
	logic         empty;
	logic         ovf;
	logic         ev_bit;

	assign cmd    = cmd_t'(s_tdata[1:0]);
	assign s_tready = state_q == ST_IDLE;
	assign accept = s_tvalid && s_tready;
	assign tick   = accept && cmd == CMD_TICK;
	assign roll   = {s_tdata[19], s_tdata[19:4]};
	assign th     = {2'b00, thresh_q};

	// Key levels: main button, then the two gyro directions.
	always_comb begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (k == 0)
				down[k] = s_tdata[2];
			else if (k == 1)
				down[k] = s_tdata[3] && (roll <= -th);
			else if (k == 2)
				down[k] = s_tdata[3] && (roll >= th);
			else
				down[k] = 1'b0;
		end
	end

	genvar g;
	generate
		for (g = 0; g < NUM_KEYS; g++) begin : g_lane
			kdef_lane u_lane (
				.clk          (clk),
				.arst_n       (arst_n),
				.tick         (tick),
				.down         (down[g]),
				.filter_ticks (filter_q),
				.long_time    (long_q[g]),
				.repeat_cycle (rep_q[g]),
				.cfg_touch    (cfg_we && g < 3 && (cfg_index == 3'(g + 2)
				               || cfg_index == 3'(g + 5))),
				.pressed      (pressed[g]),
				.ev           (ev[g])
			);
		end
	endgenerate

	// Merge: lane_q picks the key, kind_q the event (press, release, long).
	always_comb begin
		ev_bit   = 1'b0;
		put_code = '0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (lane_q == LW'(k)) begin
				case (kind_q)
					2'd0:    ev_bit = ev_s1[k].press;
					2'd1:    ev_bit = ev_s1[k].release_ev;
					default: ev_bit = ev_s1[k].long_ev;
				endcase
				put_code = 8'(3 * k) + {6'd0, kind_q} + 8'd1;
			end
		end
		if (state_q == ST_IDLE) begin
			ev_bit   = accept && cmd == CMD_INJECT;
			put_code = s_tdata[27:20];
		end
	end
	assign put = (state_q == ST_MERGE || state_q == ST_IDLE) && ev_bit;

	kdef_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.put      (put),
		.put_code (put_code),
		.get      (accept && cmd == CMD_READ),
		.clear    (accept && cmd == CMD_CLEAR),
		.get_code (get_code),
		.empty    (empty),
		.overflow (ovf)
	);

	// Configuration registers; unknown indexes and absent keys are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q <= 8'd5;
			thresh_q <= 15'd3000;
			for (int k = 0; k < NUM_KEYS; k++) begin
				long_q[k] <= (k == 0) ? 16'd50 : ((k < 3) ? 16'd30 : 16'd0);
				rep_q[k]  <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == REG_FILTER)
				filter_q <= cfg_data[7:0];
			else if (cfg_index == REG_THRESH)
				thresh_q <= cfg_data[14:0];
			for (int k = 0; k < NUM_KEYS && k < 3; k++) begin
				if (cfg_index == REG_LONG0 + 3'(k))
					long_q[k] <= cfg_data;
				if (cfg_index == REG_REPEAT0 + 3'(k))
					rep_q[k] <= cfg_data[7:0];
			end
		end
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lane_q  <= '0;
			kind_q  <= '0;
			read_q  <= 1'b0;
			code_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						lane_q  <= '0;
						kind_q  <= '0;
						read_q  <= cmd == CMD_READ;
						code_q  <= (cmd == CMD_READ && !empty) ? get_code : 8'd0;
						state_q <= (cmd == CMD_TICK) ? ST_MERGE : ST_DONE;
					end
				end
				ST_MERGE: begin
					// Advance through the kinds, then on to the next lane.
					if (kind_q == 2'd2) begin
						kind_q <= '0;
						lane_q <= lane_q + LW'(1);
						if (lane_q == LW'(NUM_KEYS - 1))
							state_q <= ST_DONE;
					end else begin
						kind_q <= kind_q + 2'd1;
					end
				end
				ST_DONE: state_q <= ST_OUT;
				ST_OUT: begin
					if (m_tready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tick)
			for (int k = 0; k < NUM_KEYS; k++)
				ev_s1[k] <= ev[k];
	end

	logic [2:0] mask;
	always_comb begin
		mask = '0;
		for (int k = 0; k < NUM_KEYS && k < 3; k++)
			mask[k] = pressed[k];
	end

	assign m_tvalid = state_q == ST_OUT;
	assign m_tdata  = {4'd0, ovf, mask, code_q};

`ifndef SYNTHESIS
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("input and output open together");
	a_read_code: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !read_q) |-> code_q == 8'd0) else $error("code on non-read");
	a_merge_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MERGE |-> (kind_q != 2'd3 && int'(lane_q) < NUM_KEYS))
		else $error("merge overrun");
`endif
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for key_debounce_event_fifo_unit: stream driver, monitor, predictor.
// Depends on kdef_pkg and the block's RTL only.
module testbench;
	import kdef_pkg::*;

	localparam int DEPTH = 16;
	localparam int KEYS  = 3;
	localparam int LIMIT = 600000;

	typedef struct {
		logic [7:0] code;
		logic [2:0] mask;
		logic       ovf;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// Commands waiting to go out, and the results they are predicted to give.
	logic [31:0] cmd_pending[$];
	result_t     result_q[$];

	// Knobs for the stimulus process.
	bit          quiet = 0;       // no random idling on either side
	bit          send_hold = 0;   // sender pause
	int          stall_req = 0;   // receiver hold-off request, in cycles
	int          mismatches = 0;
	int          cycles = 0;

	// Predictor copy of the configuration and state.
	int unsigned p_filter, p_thresh;
	int unsigned p_long[KEYS], p_rep[KEYS];
	int unsigned p_deb[KEYS], p_lcnt[KEYS], p_rcnt[KEYS];
	bit          p_pressed[KEYS];
	logic [7:0]  p_store[DEPTH];
	int unsigned p_rd, p_wr, p_fill;
	bit          p_ovf;

	key_debounce_event_fifo_unit #(.FIFO_DEPTH(DEPTH), .NUM_KEYS(KEYS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic void model_reset();
		p_filter = 5;
		p_thresh = 3000;
		p_long[0] = 50; p_long[1] = 30; p_long[2] = 30;
		for (int k = 0; k < KEYS; k++) begin
			p_rep[k] = 0;
			p_deb[k] = p_filter / 2;
			p_pressed[k] = 0;
			p_lcnt[k] = 0;
			p_rcnt[k] = 0;
		end
		p_rd = 0; p_wr = 0; p_fill = 0; p_ovf = 0;
	endfunction

	function automatic void event_put(int unsigned code);
		if (p_fill >= DEPTH) begin
			p_ovf = 1;
		end else begin
			p_store[p_wr] = code[7:0];
			p_wr = (p_wr + 1) % DEPTH;
			p_fill++;
		end
	endfunction

	// One key lane on a tick: hysteresis counter, then press/release/long/repeat.
	function automatic void lane_tick(int k, bit down);
		int unsigned f;
		int unsigned base;
		f = p_filter;
		base = 3 * k;
		if (down) begin
			if (p_deb[k] < f) begin
				p_deb[k] = f;
			end else if (p_deb[k] < 2 * f) begin
				p_deb[k]++;
			end else begin
				if (!p_pressed[k]) begin
					p_pressed[k] = 1;
					event_put(base + 1);
				end
				if (p_long[k] > 0) begin
					if (p_lcnt[k] < p_long[k]) begin
						p_lcnt[k]++;
						if (p_lcnt[k] == p_long[k])
							event_put(base + 3);
					end else if (p_rep[k] > 0) begin
						p_rcnt[k] = (p_rcnt[k] + 1) & 8'hFF;
						if (p_rcnt[k] >= p_rep[k]) begin
							p_rcnt[k] = 0;
							event_put(base + 1);
						end
					end
				end
			end
		end else begin
			if (p_deb[k] > f) begin
				p_deb[k] = f;
			end else if (p_deb[k] != 0) begin
				p_deb[k]--;
			end else if (p_pressed[k]) begin
				p_pressed[k] = 0;
				event_put(base + 2);
			end
			p_lcnt[k] = 0;
			p_rcnt[k] = 0;
		end
	endfunction

	function automatic result_t predict_result(logic [31:0] d);
		result_t r;
		cmd_t c;
		int roll;
		bit en;
		c = cmd_t'(d[1:0]);
		en = d[3];
		roll = $signed(d[19:4]);
		r.code = '0;
		case (c)
			CMD_TICK: begin
				lane_tick(0, d[2]);
				lane_tick(1, en && roll <= -int'(p_thresh));
				lane_tick(2, en && roll >= int'(p_thresh));
			end
			CMD_READ: begin
				if (p_fill != 0) begin
					r.code = p_store[p_rd];
					p_rd = (p_rd + 1) % DEPTH;
					p_fill--;
				end
			end
			CMD_INJECT: event_put(d[27:20]);
			default: begin
				p_rd = p_wr;
				p_fill = 0;
			end
		endcase
		r.mask = {p_pressed[2], p_pressed[1], p_pressed[0]};
		r.ovf = p_ovf;
		return r;
	endfunction

	// Driver: retire the accepted transaction, then offer the next one. Hold an
	// offered transaction unchanged until it is taken.
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			result_q.push_back(predict_result(s_tdata));
			void'(cmd_pending.pop_front());
		end
		if (!s_tvalid || s_tready) begin
			if (arst_n && !send_hold && cmd_pending.size() != 0 &&
			    (quiet || $urandom_range(0, 99) >= 12)) begin
				s_tvalid <= 1'b1;
				s_tdata  <= cmd_pending[0];
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: check every result transaction against the oldest prediction.
	always @(posedge clk) begin
		result_t e;
		if (m_tvalid && m_tready) begin
			if (result_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", m_tdata);
			end else begin
				e = result_q.pop_front();
				if (m_tdata[7:0] !== e.code || m_tdata[10:8] !== e.mask ||
				    m_tdata[11] !== e.ovf || m_tdata[15:12] !== 4'h0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: code %h/%h mask %b/%b ovf %b/%b (exp/act)",
							e.code, m_tdata[7:0], e.mask, m_tdata[10:8],
							e.ovf, m_tdata[11]);
				end
			end
		end
	end

	// Receiver: hold off for a long stretch on request, else idle at random.
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_req != 0 && stall_left == 0) begin
			stall_left = stall_req;
			stall_req = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n && (quiet || $urandom_range(0, 99) >= 12);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic [31:0] pack_cmd(cmd_t c, bit btn, bit en, int roll, int code);
		logic [15:0] r16;
		logic [7:0]  c8;
		r16 = roll[15:0];
		c8 = code[7:0];
		return {4'h0, c8, r16, en, btn, c};
	endfunction

	task automatic reg_write(logic [2:0] idx, int unsigned v);
		int k;
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v[15:0];
		case (idx)
			REG_FILTER: p_filter = v & 8'hFF;
			REG_THRESH: p_thresh = v & 15'h7FFF;
			REG_LONG0, REG_LONG0 + 3'd1, REG_LONG2: begin
				k = idx - REG_LONG0;
				p_long[k] = v & 16'hFFFF;
				p_rcnt[k] = 0;
			end
			default: begin
				k = idx - REG_REPEAT0;
				p_rep[k] = v & 8'hFF;
				p_rcnt[k] = 0;
			end
		endcase
	endtask

	// Write the whole register file, then drop the write enable.
	task automatic set_all(int unsigned f, int unsigned th, int unsigned l0, int unsigned l1,
	                       int unsigned l2, int unsigned r0, int unsigned r1, int unsigned r2);
		reg_write(REG_FILTER, f);
		reg_write(REG_THRESH, th);
		reg_write(REG_LONG0, l0);
		reg_write(REG_LONG0 + 3'd1, l1);
		reg_write(REG_LONG2, l2);
		reg_write(REG_REPEAT0, r0);
		reg_write(REG_REPEAT0 + 3'd1, r1);
		reg_write(REG_REPEAT2, r2);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		wait (cmd_pending.size() == 0 && result_q.size() == 0);
		repeat (12) @(posedge clk);
	endtask

	// Mostly ticks with levels held over runs so debounce and long press are
	// reached; reads keep the FIFO moving; some injects and clears as noise.
	task automatic random_cmds(int n);
		int run;
		bit btn, en;
		int roll, r, th;
		run = 0;
		for (int i = 0; i < n; i++) begin
			if (run == 0) begin
				run = $urandom_range(1, 30);
				btn = $urandom_range(0, 1);
				en = $urandom_range(0, 3) != 0;
				th = p_thresh;
				case ($urandom_range(0, 6))
					0: roll = th;
					1: roll = -th;
					2: roll = th - 1;
					3: roll = 1 - th;
					4: roll = 0;
					5: roll = $urandom_range(0, 1) ? 32767 : -32768;
					default: roll = int'($signed(16'($urandom)));
				endcase
			end
			run--;
			r = $urandom_range(0, 99);
			if (r < 60)
				cmd_pending.push_back(pack_cmd(CMD_TICK, btn, en, roll, $urandom));
			else if (r < 88)
				cmd_pending.push_back(pack_cmd(CMD_READ, 1'($urandom), 1'($urandom),
					$urandom, $urandom));
			else if (r < 96)
				cmd_pending.push_back(pack_cmd(CMD_INJECT, 1'($urandom), 1'($urandom),
					$urandom, $urandom));
			else
				cmd_pending.push_back(pack_cmd(CMD_CLEAR, 1'($urandom), 1'($urandom),
					$urandom, $urandom));
		end
	endtask

	initial begin
		model_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: empty read, inject of zero and of 255, extreme rolls,
		// overflow on a full FIFO, clear that keeps the sticky flag.
		cmd_pending.push_back(pack_cmd(CMD_READ, 1, 1, 0, 0));
		cmd_pending.push_back(pack_cmd(CMD_INJECT, 0, 0, 0, 0));
		cmd_pending.push_back(pack_cmd(CMD_INJECT, 1, 1, -1, 255));
		cmd_pending.push_back(pack_cmd(CMD_READ, 0, 0, 0, 0));
		cmd_pending.push_back(pack_cmd(CMD_READ, 0, 0, 0, 0));
		cmd_pending.push_back(pack_cmd(CMD_TICK, 1, 1, -32768, 0));
		cmd_pending.push_back(pack_cmd(CMD_TICK, 1, 1, 32767, 0));
		cmd_pending.push_back(pack_cmd(CMD_TICK, 0, 0, 0, 0));
		for (int i = 0; i < 17; i++)
			cmd_pending.push_back(pack_cmd(CMD_INJECT, 0, 0, 0, i * 15));
		cmd_pending.push_back(pack_cmd(CMD_READ, 0, 0, 0, 0));
		cmd_pending.push_back(pack_cmd(CMD_CLEAR, 0, 0, 0, 0));
		cmd_pending.push_back(pack_cmd(CMD_READ, 0, 0, 0, 0));
		drain();

		// Filter of one, zero threshold, short long press, repeat extremes.
		set_all(1, 0, 3, 4, 5, 1, 2, 255);
		random_cmds(100);
		drain();

		// Maximum threshold, long press disabled and maximal.
		set_all(3, 32767, 0, 65535, 7, 0, 3, 1);
		random_cmds(80);
		drain();

		// Slowest filter.
		set_all(255, 1500, 1, 2, 3, 255, 1, 1);
		random_cmds(40);
		drain();

		// No idling; receiver holds off while the sender keeps offering.
		set_all(2, 3000, 10, 6, 8, 4, 5, 2);
		quiet = 1;
		stall_req = 300;
		random_cmds(100);
		drain();
		quiet = 0;

		// Sender pause until every result is back, then a last stretch.
		send_hold = 1;
		random_cmds(40);
		wait (result_q.size() == 0);
		repeat (20) @(posedge clk);
		send_hold = 0;
		drain();
		repeat (30) @(posedge clk);

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
